[rtl/sticky_modifier_key_tracker_core_defines.svh]
`ifndef STICKY_MODIFIER_KEY_TRACKER_CORE_DEFINES_SVH
`define STICKY_MODIFIER_KEY_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk_i and disabled in reset
`define SMKT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i and disabled in reset
`define SMKT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/smkt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package smkt_pkg;

  // Modifier count and flag layout
  localparam int NumMods = 3;
  localparam int FlagW   = 5;
  localparam int FlagOn       = 0;
  localparam int FlagLocked   = 1;
  localparam int FlagUsed     = 2;
  localparam int FlagPressed  = 3;
  localparam int FlagReleased = 4;

  // Field widths
  localparam int OpW    = 2;
  localparam int ModW   = 2;
  localparam int SelW   = NumMods;
  localparam int LevelW = 2;

  // Default queue depth between front and back
  localparam int QueueDepthDflt = 2;

  typedef enum logic [OpW-1:0] {
    OP_KEY_DOWN     = 2'd0,
    OP_KEY_UP       = 2'd1,
    OP_ADJUST       = 2'd2,
    OP_CLEAR_LOCKED = 2'd3
  } op_e;

  typedef enum logic [ModW-1:0] {
    MOD_SHIFT = 2'd0,
    MOD_ALT   = 2'd1,
    MOD_SYM   = 2'd2,
    MOD_NONE  = 2'd3
  } mod_e;

  typedef enum logic [2:0] {
    CMD_KEY_DOWN,
    CMD_KEY_UP,
    CMD_ADJUST,
    CMD_CLEAR,
    CMD_NONE
  } cmd_kind_e;

  typedef logic [FlagW-1:0] flags_t;

  // Classified command handed from front to back
  typedef struct packed {
    cmd_kind_e          kind;
    logic [NumMods-1:0] target;
    logic               chorded;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/smkt_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface smkt_in_if;
  import smkt_pkg::*;

  logic            valid;
  logic            ready;
  logic [OpW-1:0]  operation;
  logic [ModW-1:0] modifier;
  logic            chorded;
  logic [SelW-1:0] clear_select;

  modport source (output valid, operation, modifier, chorded, clear_select, input ready);
  modport sink (input valid, operation, modifier, chorded, clear_select, output ready);
endinterface

`default_nettype wire

[rtl/smkt_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface smkt_out_if;
  import smkt_pkg::*;

  logic              valid;
  logic              ready;
  logic [LevelW-1:0] shift_level;
  logic [LevelW-1:0] alt_level;
  logic [LevelW-1:0] sym_level;
  logic              key_consumed;

  modport source (output valid, shift_level, alt_level, sym_level, key_consumed, input ready);
  modport sink (input valid, shift_level, alt_level, sym_level, key_consumed, output ready);
endinterface

`default_nettype wire

[rtl/smkt_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module smkt_front (
  smkt_in_if.sink          item_i,
  output logic             push_valid_o,
  output smkt_pkg::cmd_t   push_cmd_o,
  input  logic             push_ready_i
);
  import smkt_pkg::*;

  // Accept whenever the queue has room
  assign item_i.ready = push_ready_i;
  assign push_valid_o = item_i.valid;

  // Classify the key event into a command and a target mask
  always_comb begin
    push_cmd_o.kind    = CMD_NONE;
    push_cmd_o.target  = '0;
    push_cmd_o.chorded = item_i.chorded;
    unique case (op_e'(item_i.operation))
      OP_KEY_DOWN, OP_KEY_UP: begin
        if (item_i.modifier != MOD_NONE) begin
          push_cmd_o.kind   = (op_e'(item_i.operation) == OP_KEY_DOWN) ? CMD_KEY_DOWN
                                                                        : CMD_KEY_UP;
          push_cmd_o.target = NumMods'(1) << item_i.modifier;
        end
      end
      OP_ADJUST: begin
        push_cmd_o.kind   = CMD_ADJUST;
        push_cmd_o.target = '1;
      end
      OP_CLEAR_LOCKED: begin
        push_cmd_o.kind   = CMD_CLEAR;
        push_cmd_o.target = item_i.clear_select;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/smkt_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "sticky_modifier_key_tracker_core_defines.svh"

module smkt_fifo #(
  parameter int Depth = smkt_pkg::QueueDepthDflt
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  smkt_pkg::cmd_t push_data_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output smkt_pkg::cmd_t pop_data_o,
  input  logic           pop_ready_i
);
  import smkt_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CntW'(push) - CntW'(pop);
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `SMKT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CntW'(Depth), "queue count past depth")
  `SMKT_ASSERT_NXT(a_count_track, 1'b1, count_q == $past(count_q) + CntW'($past(push)) - CntW'($past(pop)), "queue count lost track")
  `SMKT_ASSERT_IMP(a_ptr_gap, 1'b1, (count_q == '0 || count_q == CntW'(Depth)) == (wr_ptr_q == rd_ptr_q), "queue pointers disagree with count")

endmodule

`default_nettype wire

[rtl/smkt_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "sticky_modifier_key_tracker_core_defines.svh"

module smkt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  smkt_pkg::cmd_t cmd_i,
  output logic           cmd_ready_o,
  smkt_out_if.source     result_o
);
  import smkt_pkg::*;

  localparam logic [LevelW-1:0] LevelOff    = LevelW'(0);
  localparam logic [LevelW-1:0] LevelOn     = LevelW'(1);
  localparam logic [LevelW-1:0] LevelLocked = LevelW'(2);

  flags_t            flags_q [NumMods];
  flags_t            flags_d [NumMods];
  logic [LevelW-1:0] level_q [NumMods];
  logic              consumed_q;
  logic              out_valid_q;
  logic              take;
  logic [NumMods-1:0] on_ok, rel_ok;

  function automatic flags_t key_down(flags_t s);
    flags_t r;
    r = s;
    priority if (s[FlagPressed]) begin
      r = s;
    end else if (s[FlagReleased]) begin
      r = '0;
      r[FlagOn] = 1'b1;
      r[FlagLocked] = 1'b1;
    end else if (s[FlagUsed]) begin
      r = s;
    end else if (s[FlagLocked]) begin
      r = '0;
    end else begin
      r[FlagOn] = 1'b1;
      r[FlagPressed] = 1'b1;
    end
    return r;
  endfunction

  function automatic flags_t key_up(flags_t s, logic chorded);
    flags_t r;
    r = s;
    priority if (!chorded || s[FlagUsed]) begin
      r = '0;
    end else if (s[FlagPressed]) begin
      r[FlagOn] = 1'b1;
      r[FlagReleased] = 1'b1;
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic flags_t adjust(flags_t s);
    flags_t r;
    r = s;
    priority if (s[FlagPressed]) begin
      r = '0;
      r[FlagOn] = 1'b1;
      r[FlagUsed] = 1'b1;
    end else if (s[FlagReleased]) begin
      r = '0;
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic logic [LevelW-1:0] level_of(flags_t s);
    logic [LevelW-1:0] r;
    priority if (s[FlagLocked]) begin
      r = LevelLocked;
    end else if (s[FlagOn]) begin
      r = LevelOn;
    end else begin
      r = LevelOff;
    end
    return r;
  endfunction

  // Take a command when the result register is free or drains this cycle
  assign cmd_ready_o = !out_valid_q || result_o.ready;
  assign take        = cmd_valid_i && cmd_ready_o;

  // Apply the command to each targeted modifier
  always_comb begin
    for (int i = 0; i < NumMods; i++) begin
      flags_d[i] = flags_q[i];
      if (cmd_i.target[i]) begin
        unique case (cmd_i.kind)
          CMD_KEY_DOWN: flags_d[i] = key_down(flags_q[i]);
          CMD_KEY_UP:   flags_d[i] = key_up(flags_q[i], cmd_i.chorded);
          CMD_ADJUST:   flags_d[i] = adjust(flags_q[i]);
          CMD_CLEAR:    flags_d[i] = flags_q[i][FlagLocked] ? '0 : flags_q[i];
          default:      flags_d[i] = flags_q[i];
        endcase
      end
    end
  end

  // Hold modifier state and the output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumMods; i++) begin
        flags_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        for (int i = 0; i < NumMods; i++) begin
          flags_q[i] <= flags_d[i];
        end
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int i = 0; i < NumMods; i++) begin
        level_q[i] <= level_of(flags_d[i]);
      end
      consumed_q <= (cmd_i.kind == CMD_KEY_DOWN) || (cmd_i.kind == CMD_KEY_UP);
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.shift_level  = level_q[MOD_SHIFT];
  assign result_o.alt_level    = level_q[MOD_ALT];
  assign result_o.sym_level    = level_q[MOD_SYM];
  assign result_o.key_consumed = consumed_q;

  // Flag invariants kept by the update rules
  always_comb begin
    for (int i = 0; i < NumMods; i++) begin
      on_ok[i]  = (flags_q[i] == '0) || flags_q[i][FlagOn];
      rel_ok[i] = !flags_q[i][FlagReleased] || flags_q[i][FlagPressed];
    end
  end

  `SMKT_ASSERT_IMP(a_flags_imply_on, 1'b1, &on_ok, "modifier flag set without on")
  `SMKT_ASSERT_IMP(a_released_pressed, 1'b1, &rel_ok, "released set without pressed")
  `SMKT_ASSERT_NXT(a_take_loads, take, out_valid_q, "accepted command left no result")

endmodule

`default_nettype wire

[rtl/sticky_modifier_key_tracker_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Sticky modifier tracker for shift, alt and sym. Every accepted key event
// (key down, key up, adjust after an ordinary keypress, clear locked) gives
// exactly one result with each modifier's level after the event (2 locked,
// 1 on, 0 off) and whether it was a key down or up that named a modifier.
// Events are taken one per cycle while the queue has room; the front
// classifies each event into a queue of QueueDepth entries, and the back
// applies it combinationally to the fifteen flag bits and registers the
// result. Sustained rate is one event per cycle while results are taken;
// the queue lets input keep flowing while a result waits.
module sticky_modifier_key_tracker_core #(
  parameter int QueueDepth = smkt_pkg::QueueDepthDflt
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  smkt_in_if.sink    item_i,
  smkt_out_if.source result_o
);
  import smkt_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  // Classify incoming events
  smkt_front u_front (
    .item_i       (item_i),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  // Decouple front and back
  smkt_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  // Update flags and drive results
  smkt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_i       (pop_cmd),
    .cmd_ready_o (pop_ready),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire
